// ----- rtl/core/hpm_pkg.sv -----
// ----------------------------------------------------------------------------
// hpm_pkg: shared types and constants of the hashed pointer map
// Table geometry, operation and status codes, and the classified request
// record that travels from the front part to the back part.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hpm_pkg;

   // Table geometry. BUCKETS must be a power of two: the bucket index is
   // the low bits of the folded key.
   localparam int BUCKETS     = 64;
   localparam int WAYS        = 8;
   localparam int KEY_BITS    = 64;
   localparam int VALUE_BITS  = 64;
   localparam int HASH_SHIFT  = 6;

   localparam int BUCKET_BITS = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int WAY_BITS    = (WAYS > 1) ? $clog2(WAYS) : 1;

   localparam int OP_BITS     = 2;
   localparam int STATUS_BITS = 3;

   // Depth of the queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   // Operation codes
   localparam logic [OP_BITS-1:0] OP_FIND   = 2'd0;
   localparam logic [OP_BITS-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_BITS-1:0] OP_REMOVE = 2'd2;
   localparam logic [OP_BITS-1:0] OP_CLEAR  = 2'd3;

   // Result status codes
   localparam logic [STATUS_BITS-1:0] STS_FOUND     = 3'd0;
   localparam logic [STATUS_BITS-1:0] STS_NOT_FOUND = 3'd1;
   localparam logic [STATUS_BITS-1:0] STS_INSERTED  = 3'd2;
   localparam logic [STATUS_BITS-1:0] STS_PRESENT   = 3'd3;
   localparam logic [STATUS_BITS-1:0] STS_REMOVED   = 3'd4;
   localparam logic [STATUS_BITS-1:0] STS_ABSENT    = 3'd5;
   localparam logic [STATUS_BITS-1:0] STS_FULL      = 3'd6;

   // Classified request
   typedef struct packed {
      logic [OP_BITS-1:0]     op;
      logic [KEY_BITS-1:0]    key;
      logic [VALUE_BITS-1:0]  value;
      logic [BUCKET_BITS-1:0] bucket;
      logic                   key_zero;
   } hpm_item_type;

   // Queue status seen by the front and the back
   typedef struct packed {
      logic not_empty;
      logic full;
   } hpm_q_status_type;

   // Bucket index: low bits of key xor key>>6 xor key>>12
   function automatic logic [BUCKET_BITS-1:0] hpm_bucket(input logic [KEY_BITS-1:0] key);
      logic [KEY_BITS-1:0] folded;
      folded = key ^ (key >> HASH_SHIFT) ^ (key >> (2 * HASH_SHIFT));
      return folded[BUCKET_BITS-1:0];
   endfunction

endpackage

// ----- rtl/core/hashed_pointer_map.sv -----
// ----------------------------------------------------------------------------
// hashed_pointer_map: bucketed key to value map
// Find, insert, remove and clear on a table of buckets with a fixed number
// of ways each; one result per request.
//
//   channel   direction   ports                          handshake
//   req       in          req_op, req_key, req_value     req_valid / req_stall
//   rsp       out         rsp_status, rsp_found_value    rsp_valid / rsp_stall
//
// Each request passes three steps in the back part (row read, compare,
// write-back with result); the back part takes no new request until the
// last one has been written back and its result registered.
// Reset clears the per-bucket written flags; there is no clearing pass.
// A stalled result holds in the output register while the next request is
// already read; the queue absorbs further requests until it fills.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hashed_pointer_map import hpm_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [OP_BITS-1:0]      req_op,
   input  logic [KEY_BITS-1:0]     req_key,
   input  logic [VALUE_BITS-1:0]   req_value,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [STATUS_BITS-1:0]  rsp_status,
   output logic [VALUE_BITS-1:0]   rsp_found_value
);

   hpm_q_status_type q_status;
   hpm_item_type     push_item;
   hpm_item_type     pop_item;
   logic             q_push;
   logic             q_pop;

   // Intake and classification
   hpm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_op    (req_op),
      .req_key   (req_key),
      .req_value (req_value),
      .q_status  (q_status),
      .q_push    (q_push),
      .q_item    (push_item)
   );

   // Request queue
   hpm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .status    (q_status)
   );

   // Table access and result
   hpm_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_status        (q_status),
      .q_item          (pop_item),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_found_value (rsp_found_value)
   );

endmodule

// ----- rtl/core/hpm_front.sv -----
// ----------------------------------------------------------------------------
// hpm_front: request intake and classification
// Registers each accepted request together with its bucket index and a
// zero-key flag, and hands it to the queue when there is room.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpm_front import hpm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [OP_BITS-1:0]     req_op,
   input  logic [KEY_BITS-1:0]    req_key,
   input  logic [VALUE_BITS-1:0]  req_value,
   input  hpm_q_status_type       q_status,
   output logic                   q_push,
   output hpm_item_type           q_item
);

   logic         front_valid_ff, front_valid_in;
   hpm_item_type front_item_ff;
   logic         accept;

   // Hold the request while the queue is full
   assign q_push    = front_valid_ff & ~q_status.full;
   assign req_stall = front_valid_ff & q_status.full;
   assign accept    = req_valid & ~req_stall;

   assign front_valid_in = accept | (front_valid_ff & ~q_push);
   assign q_item         = front_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   // Classify: bucket index and zero-key flag
   always_ff @(posedge clock) begin
      if (accept) begin
         front_item_ff.op       <= req_op;
         front_item_ff.key      <= req_key;
         front_item_ff.value    <= req_value;
         front_item_ff.bucket   <= hpm_bucket(req_key);
         front_item_ff.key_zero <= (req_key == '0);
      end
   end

endmodule

// ----- rtl/core/hpm_queue.sv -----
// ----------------------------------------------------------------------------
// hpm_queue: short request queue between front and back
// A small FIFO of classified requests; lets either side stall on its own.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpm_queue import hpm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  hpm_item_type     push_item,
   input  logic             pop,
   output hpm_item_type     pop_item,
   output hpm_q_status_type status
);

   localparam int PTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(QUEUE_DEPTH);
   localparam logic [PTR_BITS-1:0]   LAST_PTR   = PTR_BITS'(QUEUE_DEPTH - 1);

   hpm_item_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign status.not_empty = (count_ff != '0);
   assign status.full      = (count_ff == FULL_COUNT);
   assign do_push          = push & ~status.full;
   assign do_pop           = pop & status.not_empty;
   assign pop_item         = slot_ff[rd_ptr_ff];

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- rtl/core/hpm_back.sv -----
// ----------------------------------------------------------------------------
// hpm_back: bucket read, compare and write-back
// Holds the bucket memory. Per request: read the bucket row, compare all
// ways at once, then write the updated row back and register the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpm_back import hpm_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  hpm_q_status_type        q_status,
   input  hpm_item_type            q_item,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [STATUS_BITS-1:0]  rsp_status,
   output logic [VALUE_BITS-1:0]   rsp_found_value
);

   localparam logic [1:0] STATE_IDLE = 2'd0;
   localparam logic [1:0] STATE_READ = 2'd1;
   localparam logic [1:0] STATE_DONE = 2'd2;

   // Bucket rows: per-way valid vector, keys and values
   logic [WAYS-1:0]                  mem_valid [BUCKETS];
   logic [WAYS-1:0][KEY_BITS-1:0]    mem_key   [BUCKETS];
   logic [WAYS-1:0][VALUE_BITS-1:0]  mem_value [BUCKETS];

   // A row whose flag is clear reads as empty; clear resets all flags
   logic [BUCKETS-1:0]               row_written_ff, row_written_in;

   logic [1:0]                       state_ff, state_in;
   hpm_item_type                     cur_ff;

   logic [WAYS-1:0]                  rd_valid_ff;
   logic [WAYS-1:0][KEY_BITS-1:0]    rd_key_ff;
   logic [WAYS-1:0][VALUE_BITS-1:0]  rd_value_ff;

   logic [WAYS-1:0]                  eff_valid_ff, eff_valid;
   logic                             hit_any_ff, hit_any;
   logic [WAY_BITS-1:0]              hit_way_ff, hit_way;
   logic                             free_any_ff, free_any;
   logic [WAY_BITS-1:0]              free_way_ff, free_way;

   logic                             rd_en;
   logic                             wr_en;
   logic [WAYS-1:0]                  wr_valid_row;
   logic [WAYS-1:0][KEY_BITS-1:0]    wr_key_row;
   logic [WAYS-1:0][VALUE_BITS-1:0]  wr_value_row;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0]           rsp_status_ff, status_in;
   logic [VALUE_BITS-1:0]            rsp_value_ff, value_in;
   logic                             out_free, finish;

   assign out_free        = ~rsp_valid_ff | ~rsp_stall;
   assign finish          = (state_ff == STATE_DONE) & out_free;
   assign q_pop           = (state_ff == STATE_IDLE) & q_status.not_empty;
   assign rd_en           = q_pop;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_value = rsp_value_ff;

   // Sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         STATE_IDLE: begin
            if (q_status.not_empty) begin
               state_in = STATE_READ;
            end
         end
         STATE_READ: begin
            state_in = STATE_DONE;
         end
         STATE_DONE: begin
            if (out_free) begin
               state_in = STATE_IDLE;
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_item;
      end
   end

   // Bucket memory: registered row read, full-row write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_valid_ff <= mem_valid[q_item.bucket];
         rd_key_ff   <= mem_key[q_item.bucket];
         rd_value_ff <= mem_value[q_item.bucket];
      end
      if (wr_en) begin
         mem_valid[cur_ff.bucket] <= wr_valid_row;
         mem_key[cur_ff.bucket]   <= wr_key_row;
         mem_value[cur_ff.bucket] <= wr_value_row;
      end
   end

   // Compare all ways; lowest matching way and lowest free way
   always_comb begin
      eff_valid = row_written_ff[cur_ff.bucket] ? rd_valid_ff : '0;
      hit_any   = 1'b0;
      hit_way   = '0;
      free_any  = 1'b0;
      free_way  = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (eff_valid[w] && (rd_key_ff[w] == cur_ff.key)) begin
            hit_any = 1'b1;
            hit_way = WAY_BITS'(w);
         end
         if (!eff_valid[w]) begin
            free_any = 1'b1;
            free_way = WAY_BITS'(w);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == STATE_READ) begin
         eff_valid_ff <= eff_valid;
         hit_any_ff   <= hit_any;
         hit_way_ff   <= hit_way;
         free_any_ff  <= free_any;
         free_way_ff  <= free_way;
      end
   end

   // Result and row update
   always_comb begin
      status_in      = STS_NOT_FOUND;
      value_in       = '0;
      wr_en          = 1'b0;
      wr_valid_row   = eff_valid_ff;
      wr_key_row     = rd_key_ff;
      wr_value_row   = rd_value_ff;
      row_written_in = row_written_ff;
      unique case (cur_ff.op)
         OP_FIND: begin
            if (cur_ff.key_zero) begin
               status_in = STS_FOUND;
            end else if (hit_any_ff) begin
               status_in = STS_FOUND;
               value_in  = rd_value_ff[hit_way_ff];
            end
         end
         OP_INSERT: begin
            if (cur_ff.key_zero || hit_any_ff) begin
               status_in = STS_PRESENT;
            end else if (free_any_ff) begin
               status_in                = STS_INSERTED;
               wr_en                    = finish;
               wr_valid_row[free_way_ff] = 1'b1;
               wr_key_row[free_way_ff]   = cur_ff.key;
               wr_value_row[free_way_ff] = cur_ff.value;
            end else begin
               status_in = STS_FULL;
            end
         end
         OP_REMOVE: begin
            if (!cur_ff.key_zero && hit_any_ff) begin
               status_in                = STS_REMOVED;
               wr_en                    = finish;
               wr_valid_row[hit_way_ff] = 1'b0;
            end else begin
               status_in = STS_ABSENT;
            end
         end
         OP_CLEAR: begin
            status_in = STS_REMOVED;
            if (finish) begin
               row_written_in = '0;
            end
         end
         default: begin
            status_in = STS_NOT_FOUND;
         end
      endcase
      if (wr_en) begin
         row_written_in[cur_ff.bucket] = 1'b1;
      end
   end

   // Output register
   assign rsp_valid_in = finish | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= STATE_IDLE;
         rsp_valid_ff   <= 1'b0;
         row_written_ff <= '0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         row_written_ff <= row_written_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_status_ff <= status_in;
         rsp_value_ff  <= value_in;
      end
   end

endmodule
